### design/rgb565_nearest_downscaler_top_defines.svh
// ----------------------------------------------------------------------------
// RGB565 nearest-neighbour downscaler - assertion macros
// Shared concurrent assertion forms used by the downscaler RTL.
// ----------------------------------------------------------------------------
`ifndef RGB565_NEAREST_DOWNSCALER_TOP_DEFINES_SVH
`define RGB565_NEAREST_DOWNSCALER_TOP_DEFINES_SVH

// The expression must hold at every clock edge outside reset.
`define RGBD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rgbd: invariant violated");

// When the antecedent holds, the consequent must hold at the next clock edge.
`define RGBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbd: sequence check failed");

`endif

### design/rgbd_pkg.sv
// ----------------------------------------------------------------------------
// RGB565 downscaler package
// Types, register indexes and colour expansion shared by the downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbd_pkg;

    localparam int unsigned SIZE_W    = 12;
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned PIX_W     = 16;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned COORD_W   = 7;

    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 12'd320;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 12'd240;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_SWAP_BYTES   = 2'd2
    } cfg_index_e;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic              swap_bytes;
    } cfg_t;

    typedef struct packed {
        logic hit;
        logic last;
    } hit_t;

    // v*255/31 and v*255/63 are done as a multiply by a scaled reciprocal.
    // The product v*255 is at most 13 (14) bits, and the shift is chosen so
    // that the truncated result is exact across that whole range.
    localparam int unsigned E5_SHIFT = 18;
    localparam int unsigned E6_SHIFT = 20;
    localparam int unsigned E5_MUL   = 255 * (((1 << E5_SHIFT) + 30) / 31);
    localparam int unsigned E6_MUL   = 255 * (((1 << E6_SHIFT) + 62) / 63);

    function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] v);
        logic [26:0] prod;
        prod = 27'(v) * 27'(E5_MUL);
        return prod[E5_SHIFT +: CHAN_W];
    endfunction

    function automatic logic [CHAN_W-1:0] expand6(input logic [5:0] v);
        logic [28:0] prod;
        prod = 29'(v) * 29'(E6_MUL);
        return prod[E6_SHIFT +: CHAN_W];
    endfunction

endpackage

`default_nettype wire

### design/rgbd_cfg.sv
// ----------------------------------------------------------------------------
// Downscaler configuration registers
// Holds the frame size and swap flag, and derives the per-output source
// step (quotient and remainder of size by output size) in two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbd_cfg #(
    parameter int unsigned OUT_WIDTH  = 96,
    parameter int unsigned OUT_HEIGHT = 96,
    parameter int unsigned CRW        = 7,
    parameter int unsigned RRW        = 7
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [rgbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rgbd_pkg::CFG_W-1:0]     cfg_data,
    output rgbd_pkg::cfg_t                      cfg,
    output logic [rgbd_pkg::SIZE_W-1:0]         col_step_q,
    output logic [CRW-1:0]                      col_step_r,
    output logic [rgbd_pkg::SIZE_W-1:0]         row_step_q,
    output logic [RRW-1:0]                      row_step_r
);

    import rgbd_pkg::*;

    // Exact floor division of a 12-bit size by the output size.
    localparam int unsigned CSH     = SIZE_W + $clog2(OUT_WIDTH);
    localparam int unsigned RSH     = SIZE_W + $clog2(OUT_HEIGHT);
    localparam int unsigned CRECIP  = ((1 << CSH) + OUT_WIDTH - 1) / OUT_WIDTH;
    localparam int unsigned RRECIP  = ((1 << RSH) + OUT_HEIGHT - 1) / OUT_HEIGHT;
    localparam int unsigned PROD_W  = 2 * SIZE_W + 1;

    localparam logic [SIZE_W-1:0] OUT_W12 = SIZE_W'(OUT_WIDTH);
    localparam logic [SIZE_W-1:0] OUT_H12 = SIZE_W'(OUT_HEIGHT);

    logic [SIZE_W-1:0] fw_reg, fw_next;
    logic [SIZE_W-1:0] fh_reg, fh_next;
    logic              swap_reg, swap_next;
    logic [PROD_W-1:0] wprod_reg, wprod_next;
    logic [PROD_W-1:0] hprod_reg, hprod_next;
    logic [SIZE_W-1:0] cq_reg, cq_next;
    logic [CRW-1:0]    cr_reg, cr_next;
    logic [SIZE_W-1:0] rq_reg, rq_next;
    logic [RRW-1:0]    rr_reg, rr_next;

    always_comb
    begin
        fw_next    = fw_reg;
        fh_next    = fh_reg;
        swap_next  = swap_reg;
        wprod_next = wprod_reg;
        hprod_next = hprod_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    fw_next    = cfg_data[SIZE_W-1:0];
                    wprod_next = PROD_W'(cfg_data[SIZE_W-1:0]) * PROD_W'(CRECIP);
                end
                CFG_FRAME_HEIGHT:
                begin
                    fh_next    = cfg_data[SIZE_W-1:0];
                    hprod_next = PROD_W'(cfg_data[SIZE_W-1:0]) * PROD_W'(RRECIP);
                end
                CFG_SWAP_BYTES:
                begin
                    swap_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Second stage: quotient from the product, remainder by back-multiply.
    always_comb
    begin
        cq_next = SIZE_W'(wprod_reg >> CSH);
        rq_next = SIZE_W'(hprod_reg >> RSH);
        cr_next = CRW'(fw_reg - cq_next * OUT_W12);
        rr_next = RRW'(fh_reg - rq_next * OUT_H12);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg    <= RESET_WIDTH;
            fh_reg    <= RESET_HEIGHT;
            swap_reg  <= 1'b0;
            wprod_reg <= PROD_W'(RESET_WIDTH) * PROD_W'(CRECIP);
            hprod_reg <= PROD_W'(RESET_HEIGHT) * PROD_W'(RRECIP);
            cq_reg    <= SIZE_W'(320 / OUT_WIDTH);
            cr_reg    <= CRW'(320 % OUT_WIDTH);
            rq_reg    <= SIZE_W'(240 / OUT_HEIGHT);
            rr_reg    <= RRW'(240 % OUT_HEIGHT);
        end
        else
        begin
            fw_reg    <= fw_next;
            fh_reg    <= fh_next;
            swap_reg  <= swap_next;
            wprod_reg <= wprod_next;
            hprod_reg <= hprod_next;
            cq_reg    <= cq_next;
            cr_reg    <= cr_next;
            rq_reg    <= rq_next;
            rr_reg    <= rr_next;
        end
    end

    assign cfg.frame_width  = fw_reg;
    assign cfg.frame_height = fh_reg;
    assign cfg.swap_bytes   = swap_reg;
    assign col_step_q       = cq_reg;
    assign col_step_r       = cr_reg;
    assign row_step_q       = rq_reg;
    assign row_step_r       = rr_reg;

endmodule

`default_nettype wire

### design/rgbd_track.sv
// ----------------------------------------------------------------------------
// Downscaler position tracker
// Source and output position counters with remainder stepping of the
// selected source column and row; flags the pixels that are kept.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb565_nearest_downscaler_top_defines.svh"

module rgbd_track #(
    parameter int unsigned OUT_WIDTH  = 96,
    parameter int unsigned OUT_HEIGHT = 96,
    parameter int unsigned CRW        = 7,
    parameter int unsigned RRW        = 7,
    parameter int unsigned OXW        = 7,
    parameter int unsigned OYW        = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       fire,
    input  wire rgbd_pkg::cfg_t             cfg,
    input  wire logic [rgbd_pkg::SIZE_W-1:0] col_step_q,
    input  wire logic [CRW-1:0]             col_step_r,
    input  wire logic [rgbd_pkg::SIZE_W-1:0] row_step_q,
    input  wire logic [RRW-1:0]             row_step_r,
    output rgbd_pkg::hit_t                  hit_info,
    output logic [OXW-1:0]                  out_x,
    output logic [OYW-1:0]                  out_y
);

    import rgbd_pkg::*;

    localparam int unsigned OCW = $clog2(OUT_WIDTH + 1);
    localparam int unsigned ORW = $clog2(OUT_HEIGHT + 1);

    logic [SIZE_W-1:0] scol_reg, scol_next;
    logic [SIZE_W-1:0] srow_reg, srow_next;
    logic [OCW-1:0]    ocol_reg, ocol_next;
    logic [ORW-1:0]    orow_reg, orow_next;
    logic [SIZE_W-1:0] tcol_reg, tcol_next;
    logic [CRW-1:0]    tcol_rem_reg, tcol_rem_next;
    logic [SIZE_W-1:0] trow_reg, trow_next;
    logic [RRW-1:0]    trow_rem_reg, trow_rem_next;
    logic              done_reg, done_next;

    logic              row_hit;
    logic              col_hit;
    logic              hit;
    logic              last;
    logic              row_end;
    logic              frame_end;
    logic [CRW:0]      col_rem_sum;
    logic [RRW:0]      row_rem_sum;
    logic              col_carry;
    logic              row_carry;

    always_comb
    begin
        row_hit   = !done_reg && (orow_reg < ORW'(OUT_HEIGHT)) && (srow_reg == trow_reg);
        col_hit   = (ocol_reg < OCW'(OUT_WIDTH)) && (scol_reg == tcol_reg);
        hit       = row_hit && col_hit;
        last      = (ocol_reg == OCW'(OUT_WIDTH - 1)) && (orow_reg == ORW'(OUT_HEIGHT - 1));
        // A size of zero behaves as one: every pixel ends the row or frame.
        row_end   = ({1'b0, scol_reg} + 13'd1) >= {1'b0, cfg.frame_width};
        frame_end = row_end && (({1'b0, srow_reg} + 13'd1) >= {1'b0, cfg.frame_height});

        col_rem_sum = {1'b0, tcol_rem_reg} + {1'b0, col_step_r};
        col_carry   = col_rem_sum >= (CRW + 1)'(OUT_WIDTH);
        row_rem_sum = {1'b0, trow_rem_reg} + {1'b0, row_step_r};
        row_carry   = row_rem_sum >= (RRW + 1)'(OUT_HEIGHT);

        scol_next     = scol_reg;
        srow_next     = srow_reg;
        ocol_next     = ocol_reg;
        orow_next     = orow_reg;
        tcol_next     = tcol_reg;
        tcol_rem_next = tcol_rem_reg;
        trow_next     = trow_reg;
        trow_rem_next = trow_rem_reg;
        done_next     = done_reg;

        if (fire)
        begin
            if (hit)
            begin
                ocol_next = ocol_reg + OCW'(1);
                tcol_next = tcol_reg + col_step_q + SIZE_W'(col_carry);
                tcol_rem_next = col_carry ? CRW'(col_rem_sum - (CRW + 1)'(OUT_WIDTH))
                                          : CRW'(col_rem_sum);
                if (last)
                begin
                    done_next = 1'b1;
                end
            end

            if (row_end)
            begin
                scol_next     = '0;
                ocol_next     = '0;
                tcol_next     = '0;
                tcol_rem_next = '0;
                if (frame_end)
                begin
                    srow_next     = '0;
                    orow_next     = '0;
                    trow_next     = '0;
                    trow_rem_next = '0;
                    done_next     = 1'b0;
                end
                else
                begin
                    if (row_hit)
                    begin
                        orow_next = orow_reg + ORW'(1);
                        trow_next = trow_reg + row_step_q + SIZE_W'(row_carry);
                        trow_rem_next = row_carry ? RRW'(row_rem_sum - (RRW + 1)'(OUT_HEIGHT))
                                                  : RRW'(row_rem_sum);
                    end
                    srow_next = srow_reg + SIZE_W'(1);
                end
            end
            else
            begin
                scol_next = scol_reg + SIZE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scol_reg     <= '0;
            srow_reg     <= '0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            tcol_reg     <= '0;
            tcol_rem_reg <= '0;
            trow_reg     <= '0;
            trow_rem_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            scol_reg     <= scol_next;
            srow_reg     <= srow_next;
            ocol_reg     <= ocol_next;
            orow_reg     <= orow_next;
            tcol_reg     <= tcol_next;
            tcol_rem_reg <= tcol_rem_next;
            trow_reg     <= trow_next;
            trow_rem_reg <= trow_rem_next;
            done_reg     <= done_next;
        end
    end

    assign hit_info.hit  = hit;
    assign hit_info.last = last;
    assign out_x         = OXW'(ocol_reg);
    assign out_y         = OYW'(orow_reg);

    `RGBD_ASSERT_ALWAYS(a_ocol_range, clk, rst_n, ocol_reg <= OCW'(OUT_WIDTH))
    `RGBD_ASSERT_ALWAYS(a_orow_range, clk, rst_n, orow_reg <= ORW'(OUT_HEIGHT))
    `RGBD_ASSERT_ALWAYS(a_crem_range, clk, rst_n, 32'(tcol_rem_reg) < OUT_WIDTH)
    `RGBD_ASSERT_NEXT(a_done_set, clk, rst_n, fire && hit && last && !frame_end, done_reg)

endmodule

`default_nettype wire

### design/rgbd_out.sv
// ----------------------------------------------------------------------------
// Downscaler output stage
// Byte swap, RGB565 to RGB888 expansion and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbd_out #(
    parameter int unsigned OXW = 7,
    parameter int unsigned OYW = 7
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [rgbd_pkg::PIX_W-1:0]  pixel_in,
    input  wire logic                        swap_bytes,
    input  wire rgbd_pkg::hit_t              hit_info,
    input  wire logic [OXW-1:0]              x_in,
    input  wire logic [OYW-1:0]              y_in,
    input  wire logic                        out_ready,
    output logic                             out_free,
    output logic                             out_valid,
    output logic [rgbd_pkg::CHAN_W-1:0]      red,
    output logic [rgbd_pkg::CHAN_W-1:0]      green,
    output logic [rgbd_pkg::CHAN_W-1:0]      blue,
    output logic [OXW-1:0]                   out_x,
    output logic [OYW-1:0]                   out_y,
    output logic                             last_of_frame
);

    import rgbd_pkg::*;

    logic              valid_reg, valid_next;
    logic [PIX_W-1:0]  px;
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;
    logic [OXW-1:0]    x_reg;
    logic [OYW-1:0]    y_reg;
    logic              last_reg;

    assign px         = swap_bytes ? {pixel_in[7:0], pixel_in[15:8]} : pixel_in;
    assign out_free   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= expand5(px[15:11]);
            green_reg <= expand6(px[10:5]);
            blue_reg  <= expand5(px[4:0]);
            x_reg     <= x_in;
            y_reg     <= y_in;
            last_reg  <= hit_info.last;
        end
    end

    assign out_valid     = valid_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign out_x         = x_reg;
    assign out_y         = y_reg;
    assign last_of_frame = last_reg;

endmodule

`default_nettype wire

### design/rgb565_nearest_downscaler_top.sv
// Accepted pixels wait in the stage register and, if selected, load the result register.
// Throughput: one source pixel per clock; only an output stall held at out_ready slows it.
// A frame-size write reaches the step logic through two register stages. Reset clears all
// position counters and the stage and output valid flags, and restores a 320 by 240 source
// frame with byte swapping off.
// ----------------------------------------------------------------------------
// RGB565 nearest-neighbour downscaler
// Picks the nearest source pixel for each output position of a raster stream
// and expands it to 8 bits per channel with its position and frame end mark.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_nearest_downscaler_top #(
    parameter int unsigned OUT_WIDTH  = 96,
    parameter int unsigned OUT_HEIGHT = 96
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [rgbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rgbd_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [rgbd_pkg::PIX_W-1:0]     pixel,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rgbd_pkg::CHAN_W-1:0]         red,
    output logic [rgbd_pkg::CHAN_W-1:0]         green,
    output logic [rgbd_pkg::CHAN_W-1:0]         blue,
    output logic [rgbd_pkg::COORD_W-1:0]        out_x,
    output logic [rgbd_pkg::COORD_W-1:0]        out_y,
    output logic                                last_of_frame
);

    import rgbd_pkg::*;

    localparam int unsigned CRW = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
    localparam int unsigned RRW = (OUT_HEIGHT > 1) ? $clog2(OUT_HEIGHT) : 1;
    localparam int unsigned OXW = COORD_W;
    localparam int unsigned OYW = COORD_W;

    cfg_t              cfg;
    logic [SIZE_W-1:0] col_step_q;
    logic [CRW-1:0]    col_step_r;
    logic [SIZE_W-1:0] row_step_q;
    logic [RRW-1:0]    row_step_r;
    hit_t              hit_info;
    logic [OXW-1:0]    trk_x;
    logic [OYW-1:0]    trk_y;
    logic              out_free;

    logic              stage_valid_reg, stage_valid_next;
    logic [PIX_W-1:0]  pixel_reg;
    logic              accept;
    logic              fire;

    // The held pixel retires when it is dropped or when the result register can take it.
    assign fire             = stage_valid_reg && (!hit_info.hit || out_free);
    assign in_ready         = !stage_valid_reg || fire;
    assign accept           = in_valid && in_ready;
    assign stage_valid_next = accept || (stage_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pixel_reg <= pixel;
        end
    end

    rgbd_cfg #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT),
        .CRW        (CRW),
        .RRW        (RRW)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .col_step_q   (col_step_q),
        .col_step_r   (col_step_r),
        .row_step_q   (row_step_q),
        .row_step_r   (row_step_r)
    );

    rgbd_track #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT),
        .CRW        (CRW),
        .RRW        (RRW),
        .OXW        (OXW),
        .OYW        (OYW)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .cfg        (cfg),
        .col_step_q (col_step_q),
        .col_step_r (col_step_r),
        .row_step_q (row_step_q),
        .row_step_r (row_step_r),
        .hit_info   (hit_info),
        .out_x      (trk_x),
        .out_y      (trk_y)
    );

    rgbd_out #(
        .OXW (OXW),
        .OYW (OYW)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire && hit_info.hit),
        .pixel_in      (pixel_reg),
        .swap_bytes    (cfg.swap_bytes),
        .hit_info      (hit_info),
        .x_in          (trk_x),
        .y_in          (trk_y),
        .out_ready     (out_ready),
        .out_free      (out_free),
        .out_valid     (out_valid),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_x         (out_x),
        .out_y         (out_y),
        .last_of_frame (last_of_frame)
    );

endmodule

`default_nettype wire

### sim/tb_rgb565_nearest_downscaler_top.sv
// ----------------------------------------------------------------------------
// Testbench for the RGB565 nearest-neighbour downscaler
// Streams RGB565 pixel requests under bursty input and a stalling output,
// predicts each selected output pixel in a software copy of the scaler and
// compares every field of every result. Covers reset geometry, byte swapping,
// a whole frame with its wrap, and random frame sizes up to the extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rgb565_nearest_downscaler_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rgbd_pkg::*;

    localparam int unsigned OUT_W          = 96;
    localparam int unsigned OUT_H          = 96;
    localparam int unsigned PIPE_SETTLE    = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] x;
        logic [6:0] y;
        logic       last;
    } out_pixel_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_write_en = 1'b0;
    cfg_index_e   cfg_index = CFG_FRAME_WIDTH;
    logic [11:0]  cfg_data = '0;
    logic         in_valid = 1'b0;
    logic         in_ready;
    logic [15:0]  pixel = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic [6:0]   out_x;
    logic [6:0]   out_y;
    logic         last_of_frame;

    // Software copy of the scaler: geometry, position counters and targets.
    int unsigned  cur_width;
    int unsigned  cur_height;
    bit           cur_swap;
    int unsigned  src_col;
    int unsigned  src_row;
    int unsigned  out_col;
    int unsigned  out_row;
    int unsigned  tgt_col;
    int unsigned  tgt_col_rem;
    int unsigned  tgt_row;
    int unsigned  tgt_row_rem;
    bit           frame_done;

    out_pixel_t   pending_pixels[$];
    int unsigned  mismatches = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  burst_left = 0;
    int unsigned  stall_run = 0;
    int unsigned  stall_mode = 0;
    int unsigned  stall_tick = 0;

    rgb565_nearest_downscaler_top #(
        .OUT_WIDTH  (OUT_W),
        .OUT_HEIGHT (OUT_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_x         (out_x),
        .out_y         (out_y),
        .last_of_frame (last_of_frame)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] widen(input int unsigned v, input int unsigned full);
        return 8'((v * 255) / full);
    endfunction

    function automatic void reset_scaler();
        cur_width   = 320;
        cur_height  = 240;
        cur_swap    = 1'b0;
        src_col     = 0;
        src_row     = 0;
        out_col     = 0;
        out_row     = 0;
        tgt_col     = 0;
        tgt_col_rem = 0;
        tgt_row     = 0;
        tgt_row_rem = 0;
        frame_done  = 1'b0;
    endfunction

    // Advances the scaler by one source pixel and queues the output pixel, if any.
    function automatic void scale_pixel(input logic [15:0] pin);
        logic [15:0] p;
        bit          row_sel;
        bit          col_sel;
        bit          is_last;
        out_pixel_t  o;
        p = pin;
        row_sel = !frame_done && (out_row < OUT_H) && (src_row == tgt_row);
        col_sel = (out_col < OUT_W) && (src_col == tgt_col);
        if (row_sel && col_sel)
        begin
            is_last = (out_col == OUT_W - 1) && (out_row == OUT_H - 1);
            if (cur_swap)
                p = {p[7:0], p[15:8]};
            o.red   = widen(p[15:11], 31);
            o.green = widen(p[10:5], 63);
            o.blue  = widen(p[4:0], 31);
            o.x     = out_col[6:0];
            o.y     = out_row[6:0];
            o.last  = is_last;
            pending_pixels.push_back(o);
            if (is_last)
                frame_done = 1'b1;
            out_col++;
            tgt_col     += cur_width / OUT_W;
            tgt_col_rem += cur_width % OUT_W;
            if (tgt_col_rem >= OUT_W)
            begin
                tgt_col_rem -= OUT_W;
                tgt_col++;
            end
        end
        if (src_col + 1 >= cur_width)
        begin
            src_col     = 0;
            out_col     = 0;
            tgt_col     = 0;
            tgt_col_rem = 0;
            if (src_row + 1 >= cur_height)
            begin
                src_row     = 0;
                out_row     = 0;
                tgt_row     = 0;
                tgt_row_rem = 0;
                frame_done  = 1'b0;
            end
            else
            begin
                if (row_sel)
                begin
                    out_row++;
                    tgt_row     += cur_height / OUT_H;
                    tgt_row_rem += cur_height % OUT_H;
                    if (tgt_row_rem >= OUT_H)
                    begin
                        tgt_row_rem -= OUT_H;
                        tgt_row++;
                    end
                end
                src_row++;
            end
        end
        else
        begin
            src_col++;
        end
    endfunction

    // Register writes, pixel requests and results are all sampled here, so the
    // prediction follows exactly what the block saw at each edge.
    always @(posedge clk)
    begin
        out_pixel_t want;
        out_pixel_t got;
        if (rst_n)
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  cur_width  = cfg_data;
                    CFG_FRAME_HEIGHT: cur_height = cfg_data;
                    CFG_SWAP_BYTES:   cur_swap   = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                scale_pixel(pixel);
            if (out_valid && out_ready)
            begin
                got = '{red, green, blue, out_x, out_y, last_of_frame};
                if (pending_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: %p", got);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("result mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
        end
    end

    // The receiver switches between free flow, random stalls and a fixed duty cycle.
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(20, 200);
        end
        else
        begin
            stall_run--;
        end
        stall_tick++;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (stall_tick % 5 == 0);
            default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_rgb565_nearest_downscaler_top NOT OK");
            $finish;
        end
    end

    // Presents one pixel request and returns at the edge where it is taken.
    task automatic send_pixel(input logic [15:0] p);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Geometry is only changed once the pipeline has emptied.
    task automatic set_geometry(input logic [11:0] w, input logic [11:0] h, input bit swap);
        drain_results();
        repeat (PIPE_SETTLE) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_FRAME_WIDTH;
        cfg_data     <= w;
        @(posedge clk);
        cfg_index    <= CFG_FRAME_HEIGHT;
        cfg_data     <= h;
        @(posedge clk);
        cfg_index    <= CFG_SWAP_BYTES;
        cfg_data     <= {11'd0, swap};
        @(posedge clk);
        cfg_write_en <= 1'b0;
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic test_reset_geometry();
        logic [15:0] pats[8] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
                                 16'h001F, 16'h0821, 16'h8410, 16'h7BEF};
        foreach (pats[i])
            send_pixel(pats[i]);
    endtask

    // With a 96-pixel row every column is selected, so channel extremes show up.
    task automatic test_swap_extremes();
        logic [15:0] swapped[6] = '{16'hFFFF, 16'h0000, 16'h00F8,
                                    16'hE007, 16'h1F00, 16'h5555};
        logic [15:0] plain[6]   = '{16'hF800, 16'h07E0, 16'h001F,
                                    16'hFFFF, 16'h0000, 16'hAAAA};
        set_geometry(12'd96, 12'd96, 1'b1);
        foreach (swapped[i])
            send_pixel(swapped[i]);
        set_geometry(12'd96, 12'd96, 1'b0);
        foreach (plain[i])
            send_pixel(plain[i]);
    endtask

    // A whole frame 100 rows high: one-pixel rows step the row target with a
    // remainder up to the last output row, then full 96-pixel rows give the
    // last pixel mark, a row beyond the last output row and the wrap into the
    // next frame.
    task automatic test_full_frame();
        bit swap;
        swap = 1'($urandom_range(0, 1));
        set_geometry(12'd1, 12'd100, swap);
        repeat (98)
            send_pixel(16'($urandom_range(0, 65535)));
        set_geometry(12'd96, 12'd100, swap);
        repeat (3 * 96)
            send_pixel(16'($urandom_range(0, 65535)));
    endtask

    function automatic logic [11:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 12'd96;
        if (r < 20)
            return 12'd4095;
        if (r < 80)
            return 12'($urandom_range(96, 200));
        return 12'($urandom_range(96, 4095));
    endfunction

    task automatic test_random_geometry();
        logic [11:0] w;
        logic [11:0] h;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       begin w = 12'd4095; h = 12'd4095; end
                1:       begin w = 12'd96;   h = 12'd96;   end
                default: begin w = pick_size(); h = pick_size(); end
            endcase
            set_geometry(w, h, 1'($urandom_range(0, 1)));
            for (int n = 0; n < 150; n++)
            begin
                // Let every outstanding request complete once, mid-stream.
                if (phase == 4 && n == 75)
                    drain_results();
                send_pixel(16'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial
    begin
        reset_scaler();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry();
        test_swap_extremes();
        test_full_frame();
        test_random_geometry();
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("tb_rgb565_nearest_downscaler_top OK");
        else
            $display("tb_rgb565_nearest_downscaler_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/rgbd_pkg.sv
design/rgbd_cfg.sv
design/rgbd_track.sv
design/rgbd_out.sv
design/rgb565_nearest_downscaler_top.sv
sim/tb_rgb565_nearest_downscaler_top.sv
